// ===== design/assert_macros.svh =====
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on the block clock clk_i and reset rst_ni.
`define ASSERT_STD(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 decoder.
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HELD_N  = 3;
  localparam int unsigned RES_N   = 4;
  localparam int unsigned CNT_W   = 3;

  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_END  = 8'hF5;
  localparam logic [CP_W-1:0]   CP_MAX    = 21'h13FFFF;

  // Sequence progress: which lead and how many continuations are held.
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_2B     = 7'b0000010,
    PH_3B     = 7'b0000100,
    PH_3B_C1  = 7'b0001000,
    PH_4B     = 7'b0010000,
    PH_4B_C1  = 7'b0100000,
    PH_4B_C2  = 7'b1000000
  } u8d_phase_e;

  typedef logic [HELD_N-1:0][BYTE_W-1:0] u8d_held_t;

  // Results produced by one input beat.
  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [RES_N-1:0][CP_W-1:0]  cp;
  } u8d_res_t;

endpackage

// ===== design/u8d_if.sv =====
// Valid/ready channel interfaces for input bytes and decoded code points.
`timescale 1ns / 1ps
interface u8d_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::BYTE_W-1:0]  data_byte;
  logic                        flush;

  modport source (output valid, output data_byte, output flush, input ready);
  modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

interface u8d_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CP_W-1:0]  code_point;
  logic                      last;

  modport source (output valid, output code_point, output last, input ready);
  modport sink   (input valid, input code_point, input last, output ready);
endinterface

// ===== design/utf8_decoder_latin1_fallback.sv =====
// Top level of the UTF-8 decoder with raw Latin-1 fallback.
//
// in_i carries one text byte per beat, or a flush beat that releases any
// partly received sequence as raw byte values. out_o carries code points;
// last marks the final result caused by one input beat. A beat that only
// extends a sequence, or a flush with nothing held, yields no result.
// The decode runs in the accepting cycle and its results are registered,
// so the first result of a beat is visible in the cycle after acceptance.
// One input beat is taken every cycle while each beat yields at most one
// result and the receiver keeps up; a broken sequence unwinds up to four
// results, one per cycle while the receiver is ready, and in_i waits
// until the last of them leaves. When the receiver stalls, the result
// register holds its head entry and in_i keeps ready low for as long as
// any result is waiting to leave. Reset empties the result register and
// drops any held sequence; the held byte storage is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8_decoder_latin1_fallback (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8d_in_if.sink      in_i,
  u8d_out_if.source   out_o
);
  import u8d_pkg::*;

  u8d_phase_e  phase_q, phase_d;
  u8d_held_t   held_q, held_d;
  u8d_res_t    dec_res;
  logic        in_acc;
  logic        q_ready;

  assign in_i.ready = q_ready;
  assign in_acc     = in_i.valid && q_ready;

  u8d_decode u_decode (
    .phase_i     (phase_q),
    .held_i      (held_q),
    .data_byte_i (in_i.data_byte),
    .flush_i     (in_i.flush),
    .phase_o     (phase_d),
    .held_o      (held_d),
    .res_o       (dec_res)
  );

  u8d_result_q u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .res_i   (dec_res),
    .ready_o (q_ready),
    .out_o   (out_o)
  );

  // Advance the sequence state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (in_acc) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_q <= held_d;
    end
  end

  // A flush always leaves no sequence pending
  `ASSERT_STD(a_flush_idle, in_acc && in_i.flush |=> phase_q == PH_IDLE)
  // An ASCII byte with nothing pending comes out alone on the next cycle
  `ASSERT_STD(a_ascii_pass, in_acc && !in_i.flush && phase_q == PH_IDLE &&
    !in_i.data_byte[7] |=> out_o.valid && out_o.last &&
    out_o.code_point == {{(CP_W-BYTE_W){1'b0}}, $past(in_i.data_byte)})
  // Decoded values never exceed CP_MAX, the largest value a lead below F5 gives
  `ASSERT_STD(a_cp_range, out_o.valid |-> out_o.code_point <= CP_MAX)

endmodule

// ===== design/u8d_decode.sv =====
// Combinational decode of one byte against the held sequence state.
`timescale 1ns / 1ps
module u8d_decode (
  input  u8d_pkg::u8d_phase_e              phase_i,
  input  u8d_pkg::u8d_held_t               held_i,
  input  logic [u8d_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                             flush_i,
  output u8d_pkg::u8d_phase_e              phase_o,
  output u8d_pkg::u8d_held_t               held_o,
  output u8d_pkg::u8d_res_t                res_o
);
  import u8d_pkg::*;

  logic       is_cont;
  logic       do_release;
  logic [1:0] held_n;

  assign is_cont = (data_byte_i[7:6] == 2'b10);

  // Count the bytes held for the current phase
  always_comb begin
    unique case (phase_i)
      PH_2B, PH_3B, PH_4B: held_n = 2'd1;
      PH_3B_C1, PH_4B_C1:  held_n = 2'd2;
      PH_4B_C2:            held_n = 2'd3;
      default:             held_n = 2'd0;
    endcase
  end

  // A flush, a non-continuation byte or an idle phase unwinds the held bytes
  assign do_release = flush_i || !is_cont || (phase_i == PH_IDLE);

  always_comb begin
    res_o   = '0;
    phase_o = phase_i;
    held_o  = held_i;

    if (do_release) begin
      // Drop held bytes out raw, in arrival order
      for (int i = 0; i < HELD_N; i++) begin
        res_o.cp[i] = {{(CP_W-BYTE_W){1'b0}}, held_i[i]};
      end
      res_o.cnt = {1'b0, held_n};
      phase_o   = PH_IDLE;

      if (!flush_i) begin
        // Handle the byte as a fresh start
        if (data_byte_i < LEAD2_MIN || data_byte_i >= LEAD_END) begin
          res_o.cp[held_n] = {{(CP_W-BYTE_W){1'b0}}, data_byte_i};
          res_o.cnt        = {1'b0, held_n} + 3'd1;
        end else begin
          held_o[0] = data_byte_i;
          if (data_byte_i < LEAD3_MIN) begin
            phase_o = PH_2B;
          end else if (data_byte_i < LEAD4_MIN) begin
            phase_o = PH_3B;
          end else begin
            phase_o = PH_4B;
          end
        end
      end
    end else begin
      // Continuation byte: hold it or complete the sequence
      unique case (phase_i)
        PH_2B: begin
          res_o.cp[0] = {10'd0, held_i[0][4:0], data_byte_i[5:0]};
          res_o.cnt   = 3'd1;
          phase_o     = PH_IDLE;
        end
        PH_3B_C1: begin
          res_o.cp[0] = {5'd0, held_i[0][3:0], held_i[1][5:0], data_byte_i[5:0]};
          res_o.cnt   = 3'd1;
          phase_o     = PH_IDLE;
        end
        PH_4B_C2: begin
          res_o.cp[0] = {held_i[0][2:0], held_i[1][5:0], held_i[2][5:0],
                         data_byte_i[5:0]};
          res_o.cnt   = 3'd1;
          phase_o     = PH_IDLE;
        end
        PH_3B: begin
          held_o[1] = data_byte_i;
          phase_o   = PH_3B_C1;
        end
        PH_4B: begin
          held_o[1] = data_byte_i;
          phase_o   = PH_4B_C1;
        end
        PH_4B_C1: begin
          held_o[2] = data_byte_i;
          phase_o   = PH_4B_C2;
        end
        default: begin
          phase_o = PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/u8d_result_q.sv =====
// Result register: holds up to four code points and drains them one per beat.
`timescale 1ns / 1ps
module u8d_result_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  u8d_pkg::u8d_res_t  res_i,
  output logic               ready_o,
  u8d_out_if.source          out_o
);
  import u8d_pkg::*;

  logic [CNT_W-1:0]            num_q, num_d;
  logic [RES_N-1:0][CP_W-1:0]  buf_q, buf_d;
  logic                        pop;

  assign pop     = (num_q != '0) && out_o.ready;
  // Take a new load when empty or when the final entry leaves this cycle
  assign ready_o = (num_q == '0) || ((num_q == 3'd1) && out_o.ready);

  assign out_o.valid      = (num_q != '0);
  assign out_o.code_point = buf_q[0];
  assign out_o.last       = (num_q == 3'd1);

  // Load a fresh set or shift the next entry to the head
  always_comb begin
    num_d = num_q;
    buf_d = buf_q;
    if (load_i) begin
      num_d = res_i.cnt;
      buf_d = res_i.cp;
    end else if (pop) begin
      num_d = num_q - 3'd1;
      for (int i = 0; i < RES_N - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else begin
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule
